// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Character codes, stack entry kinds, field widths and decode helpers.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int DEPTH_W = 7;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_OPEN_PAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_OPEN_BRACE  = 8'h7B;
    localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE_PAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE_BRACE = 8'h7D;

    localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRACE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;

    function automatic logic is_opening(input logic [CHAR_W-1:0] c);
        is_opening = (c == CHAR_OPEN_PAREN) || (c == CHAR_OPEN_BRACE) ||
                     (c == CHAR_OPEN_SQUARE);
    endfunction

    // Any byte that is not a known bracket counts as a closing square bracket.
    function automatic logic [KIND_W-1:0] char_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        k = KIND_SQUARE;
        if ((c == CHAR_OPEN_PAREN) || (c == CHAR_CLOSE_PAREN))
        begin
            k = KIND_PAREN;
        end
        else if ((c == CHAR_OPEN_BRACE) || (c == CHAR_CLOSE_BRACE))
        begin
            k = KIND_BRACE;
        end
        char_kind = k;
    endfunction

endpackage

// ===== rtl/bracket_balance_checker_unit.sv =====
// A result is registered in the output register, or in the skid stage if stalled.
// Throughput: one character per cycle while the skid stage is empty; the top
// of stack sits in a register and the entry below it is read from the stack
// memory ahead of time, so pops and pushes follow each other with no bubble.
// Reset clears the stack count, the error flag and the output valid flags; the
// stack memory itself is not cleared.
// ----------------------------------------------------------------------------
// Bracket balance checker
// Checks bracket nesting of a byte stream with a memory-based stack and
// reports depth, sticky error and the balanced verdict for every character.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,   // [7:0] character
    input  logic                   s_tuser,   // [0] has_char
    input  logic                   s_tlast,   // last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] balanced, [1] error_seen,
                                              // [8:2] depth, [15:9] zero
    output logic                   m_tlast    // done_res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [KIND_W-1:0] stack_mem [STACK_DEPTH];

    logic [CW-1:0]          count_reg, count_next, cnt_upd, rd_sum;
    logic                   err_reg, err_next, err_upd;
    logic [KIND_W-1:0]      top_reg, top_next;
    logic [KIND_W-1:0]      below_reg;
    logic [AW-1:0]          rd_addr;

    logic                   out_valid_reg, out_last_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   skid_valid_reg, skid_last_reg;
    logic [OUT_TDATA_W-1:0] skid_data_reg;

    logic                   accept, apply, opening, push_ok, pop_ok, err_set;
    logic [KIND_W-1:0]      kind;
    logic                   balanced;
    logic [OUT_TDATA_W-1:0] res_data;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign apply    = accept && s_tuser && !err_reg;
    assign opening  = is_opening(s_tdata);
    assign kind     = char_kind(s_tdata);

    assign push_ok = apply && opening && (count_reg != CW'(STACK_DEPTH));
    assign pop_ok  = apply && !opening && (count_reg != '0) && (top_reg == kind);
    assign err_set = apply && !push_ok && !pop_ok;

    always_comb
    begin
        cnt_upd  = count_reg;
        top_next = top_reg;
        if (push_ok)
        begin
            cnt_upd  = count_reg + CW'(1);
            top_next = kind;
        end
        else if (pop_ok)
        begin
            cnt_upd  = count_reg - CW'(1);
            top_next = below_reg;
        end
    end

    assign err_upd    = err_reg || err_set;
    assign count_next = (accept && s_tlast) ? '0 : cnt_upd;
    assign err_next   = (accept && s_tlast) ? 1'b0 : err_upd;

    // Fetch the entry just below the next top of stack, so a pop in the next cycle
    // finds its new top ready. It can meet the push write only as a string ends.
    assign rd_sum  = count_next - CW'(2);
    assign rd_addr = rd_sum[AW-1:0];

    assign balanced = s_tlast && !err_upd && (cnt_upd == '0);
    assign res_data = {(OUT_TDATA_W - DEPTH_W - 2)'(0), DEPTH_W'(cnt_upd), err_upd, balanced};

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            stack_mem[count_reg[AW-1:0]] <= kind;
        end
        below_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_data_reg <= res_data;
                out_last_reg <= s_tlast;
            end
            else
            begin
                skid_data_reg <= res_data;
                skid_last_reg <= s_tlast;
            end
        end
        else if (skid_valid_reg && m_tready)
        begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker port checks
// Port-level properties of the checker's result stream and buffering.
// ----------------------------------------------------------------------------
module bbc_checker
    import bbc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // A stalled result transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result transaction dropped while stalled");

    // Input back-pressure only happens with a result waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with an empty output");

    // Every accepted input transaction leaves a result on offer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
    else $error("no result offered after an input transaction");

    // Only the closing result of a string may report balanced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !m_tdata[0])
    else $error("balanced set on a result that does not close the string");

    // A balanced verdict means no error and an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (!m_tdata[1] && (m_tdata[8:2] == '0)))
    else $error("balanced verdict with error or open brackets");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== dv/tb_bracket_balance_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker testbench
// Streams strings of brackets and noise bytes through the checker with random
// gaps on both sides, predicts every result with a private stack model and
// compares each output transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker_unit
    import bbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CHAR_W-1:0] CLOSE_SQUARE = 8'h5D;
    localparam int                STALL_LEN    = 400;
    localparam int                IDLE_LIMIT   = 3000;
    localparam int                PHASE_ITEMS  = 175;
    localparam int                PRINT_CAP    = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has;
        logic              last;
    } char_item_t;

    typedef struct packed {
        logic               done;
        logic               balanced;
        logic               err;
        logic [DEPTH_W-1:0] depth;
    } verdict_t;

    typedef struct packed {
        logic                   last;
        logic [OUT_TDATA_W-1:0] data;
    } out_beat_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    char_item_t pending_q[$];
    verdict_t   verdict_q[$];
    out_beat_t  arrived_q[$];
    char_item_t next_item;
    out_beat_t  got_beat;
    verdict_t   want;

    int src_idle_pct = 31;
    int snk_idle_pct = 70;
    int stall_token  = 0;
    int stall_seen;
    int stall_left;
    int idle_cycles  = 0;
    int phase_items;
    int mismatches   = 0;

    // Private copy of the checker state.
    logic [KIND_W-1:0] kind_stack [STACK_DEPTH_DEF];
    int unsigned       nest_count  = 0;
    logic              sticky_err  = 1'b0;

    int unsigned chars_sent    = 0;
    int unsigned strings_done  = 0;
    int unsigned strings_ok    = 0;
    int unsigned strings_bad   = 0;
    int unsigned deepest       = 0;
    int unsigned full_pushes   = 0;

    bracket_balance_checker_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic verdict_t predict_verdict(input char_item_t it);
        verdict_t          v;
        logic [KIND_W-1:0] k;
        logic              opening;
        opening = (it.ch == CHAR_OPEN_PAREN) || (it.ch == CHAR_OPEN_BRACE) ||
                  (it.ch == CHAR_OPEN_SQUARE);
        if ((it.ch == CHAR_OPEN_PAREN) || (it.ch == CHAR_CLOSE_PAREN))
        begin
            k = KIND_PAREN;
        end
        else if ((it.ch == CHAR_OPEN_BRACE) || (it.ch == CHAR_CLOSE_BRACE))
        begin
            k = KIND_BRACE;
        end
        else
        begin
            k = KIND_SQUARE;
        end
        if (it.has)
        begin
            chars_sent++;
        end
        // Once the error is set the stack stays frozen until the string ends.
        if (it.has && !sticky_err)
        begin
            if (opening)
            begin
                if (nest_count >= STACK_DEPTH_DEF)
                begin
                    sticky_err = 1'b1;
                    full_pushes++;
                end
                else
                begin
                    kind_stack[nest_count] = k;
                    nest_count++;
                end
            end
            else if ((nest_count == 0) || (kind_stack[nest_count-1] != k))
            begin
                sticky_err = 1'b1;
            end
            else
            begin
                nest_count--;
            end
        end
        if (nest_count > deepest)
        begin
            deepest = nest_count;
        end
        v.done     = it.last;
        v.balanced = it.last && !sticky_err && (nest_count == 0);
        v.err      = sticky_err;
        v.depth    = DEPTH_W'(nest_count);
        if (it.last)
        begin
            strings_done++;
            if (v.balanced)
            begin
                strings_ok++;
            end
            if (sticky_err)
            begin
                strings_bad++;
            end
            nest_count = 0;
            sticky_err = 1'b0;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (mismatches < PRINT_CAP)
        begin
            $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got,
                     exp_val);
        end
        mismatches++;
    endtask

    // Sender side: holds an offered transaction until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                verdict_q.push_back(predict_verdict('{s_tdata, s_tuser, s_tlast}));
            end
            if (!s_tvalid || s_tready)
            begin
                if ((pending_q.size() > 0) && ($urandom_range(0, 99) >= src_idle_pct))
                begin
                    next_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.ch;
                    s_tuser  <= next_item.has;
                    s_tlast  <= next_item.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: collects results and throttles m_tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_seen <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                arrived_q.push_back('{m_tlast, m_tdata});
            end
            if (stall_token != stall_seen)
            begin
                stall_seen <= stall_token;
                stall_left <= STALL_LEN;
                m_tready   <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Comparison runs on the falling edge, so both queues are settled.
    always @(negedge clk)
    begin
        while (arrived_q.size() > 0)
        begin
            got_beat = arrived_q.pop_front();
            if (verdict_q.size() == 0)
            begin
                report_mismatch("result with no expectation", got_beat.data, 0);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got_beat.last !== want.done)
                    report_mismatch("done_res", got_beat.last, want.done);
                if (got_beat.data[0] !== want.balanced)
                    report_mismatch("balanced", got_beat.data[0], want.balanced);
                if (got_beat.data[1] !== want.err)
                    report_mismatch("error_seen", got_beat.data[1], want.err);
                if (got_beat.data[8:2] !== want.depth)
                    report_mismatch("depth", got_beat.data[8:2], want.depth);
                if (got_beat.data[15:9] !== '0)
                    report_mismatch("padding", got_beat.data[15:9], 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] opener_of(input logic [KIND_W-1:0] k);
        case (k)
            KIND_PAREN: return CHAR_OPEN_PAREN;
            KIND_BRACE: return CHAR_OPEN_BRACE;
            default:    return CHAR_OPEN_SQUARE;
        endcase
    endfunction

    // A square closer is either the real ']' or any byte that is no bracket.
    function automatic logic [CHAR_W-1:0] closer_of(input logic [KIND_W-1:0] k);
        logic [CHAR_W-1:0] b;
        case (k)
            KIND_PAREN: b = CHAR_CLOSE_PAREN;
            KIND_BRACE: b = CHAR_CLOSE_BRACE;
            default:
            begin
                b = CLOSE_SQUARE;
                if ($urandom_range(0, 1))
                begin
                    b = rand_byte();
                    while ((b == CHAR_OPEN_PAREN) || (b == CHAR_OPEN_BRACE) ||
                           (b == CHAR_OPEN_SQUARE) || (b == CHAR_CLOSE_PAREN) ||
                           (b == CHAR_CLOSE_BRACE))
                    begin
                        b = rand_byte();
                    end
                end
            end
        endcase
        return b;
    endfunction

    task automatic add_char(input logic [CHAR_W-1:0] ch, input logic has,
                            input logic last);
        pending_q.push_back('{ch, has, last});
        phase_items++;
    endtask

    // Push n random openers, then close them all in reverse order.
    task automatic gen_deep(input int n);
        logic [KIND_W-1:0] open_kinds[$];
        logic [KIND_W-1:0] k;
        repeat (n)
        begin
            k = KIND_W'($urandom_range(0, 2));
            open_kinds.push_back(k);
            add_char(opener_of(k), 1'b1, 1'b0);
        end
        while (open_kinds.size() > 1)
        begin
            add_char(closer_of(open_kinds.pop_back()), 1'b1, 1'b0);
        end
        add_char(closer_of(open_kinds.pop_back()), 1'b1, 1'b1);
    endtask

    task automatic gen_string();
        char_item_t        str[$];
        logic [KIND_W-1:0] open_kinds[$];
        logic [KIND_W-1:0] k;
        int                mode;
        int                opens_left;
        int                pos;
        mode = $urandom_range(0, 99);
        if (mode < 8)
        begin
            str.push_back('{rand_byte(), 1'b0, 1'b0});
        end
        else if (mode < 22)
        begin
            repeat ($urandom_range(1, 12))
            begin
                str.push_back('{rand_byte(), ($urandom_range(0, 7) != 0), 1'b0});
            end
        end
        else
        begin
            opens_left = $urandom_range(0, 14);
            while ((opens_left > 0) || (open_kinds.size() > 0))
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    str.push_back('{rand_byte(), 1'b0, 1'b0});
                end
                if ((opens_left > 0) && ((open_kinds.size() == 0) || $urandom_range(0, 1)))
                begin
                    k = KIND_W'($urandom_range(0, 2));
                    open_kinds.push_back(k);
                    str.push_back('{opener_of(k), 1'b1, 1'b0});
                    opens_left--;
                end
                else
                begin
                    str.push_back('{closer_of(open_kinds.pop_back()), 1'b1, 1'b0});
                end
            end
            // About a third of the bracket strings get one random bracket swapped in or a cut tail.
            if ((mode >= 75) && (str.size() > 0))
            begin
                if ($urandom_range(0, 1))
                begin
                    pos = $urandom_range(0, str.size() - 1);
                    str[pos].ch  = $urandom_range(0, 1) ?
                                   opener_of(KIND_W'($urandom_range(0, 2))) :
                                   closer_of(KIND_W'($urandom_range(0, 2)));
                    str[pos].has = 1'b1;
                end
                else
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        if (str.size() > 1)
                        begin
                            void'(str.pop_back());
                        end
                    end
                end
            end
        end
        if ((str.size() == 0) || ($urandom_range(0, 3) == 0))
        begin
            str.push_back('{rand_byte(), 1'b0, 1'b0});
        end
        str[str.size()-1].last = 1'b1;
        foreach (str[i])
        begin
            add_char(str[i].ch, str[i].has, str[i].last);
        end
    endtask

    task automatic gen_phase(input int deep_n);
        phase_items = 0;
        if (deep_n > 0)
        begin
            gen_deep(deep_n);
        end
        while (phase_items < PHASE_ITEMS)
        begin
            gen_string();
        end
    endtask

    task automatic wait_drained();
        while ((pending_q.size() > 0) || s_tvalid || (verdict_q.size() > 0))
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        // Empty string.
        add_char(8'h00, 1'b0, 1'b1);
        // Simple matched pairs, including ']' and a non-bracket byte as closers.
        add_char(CHAR_OPEN_PAREN, 1'b1, 1'b0);
        add_char(CHAR_CLOSE_PAREN, 1'b1, 1'b1);
        add_char(CHAR_OPEN_BRACE, 1'b1, 1'b0);
        add_char(CHAR_OPEN_SQUARE, 1'b1, 1'b0);
        add_char(CLOSE_SQUARE, 1'b1, 1'b0);
        add_char(CHAR_CLOSE_BRACE, 1'b1, 1'b1);
        add_char(CHAR_OPEN_SQUARE, 1'b1, 1'b0);
        add_char(8'hFF, 1'b1, 1'b1);
        // A state-only report in the middle of a string.
        add_char(CHAR_OPEN_SQUARE, 1'b1, 1'b0);
        add_char(8'hFF, 1'b0, 1'b0);
        add_char(8'h00, 1'b1, 1'b1);
        // Pop from an empty stack.
        add_char(CHAR_CLOSE_PAREN, 1'b1, 1'b1);
        // Wrong kind, then characters that must not touch the frozen stack.
        add_char(CHAR_OPEN_PAREN, 1'b1, 1'b0);
        add_char(CHAR_CLOSE_BRACE, 1'b1, 1'b0);
        add_char(CHAR_OPEN_PAREN, 1'b1, 1'b0);
        add_char(CHAR_CLOSE_PAREN, 1'b1, 1'b1);
        // Unclosed string ended by an item with no character.
        add_char(CHAR_OPEN_PAREN, 1'b1, 1'b0);
        add_char(CHAR_OPEN_PAREN, 1'b1, 1'b0);
        add_char(8'hA5, 1'b0, 1'b1);

        // First random phase opens with a string that fills the stack exactly.
        gen_phase(STACK_DEPTH_DEF);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        wait_drained();

        src_idle_pct = 70;
        snk_idle_pct = 31;
        gen_phase(0);
        wait_drained();

        // No idling, but a long receiver hold-off while an overflowing string streams in.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_token++;
        gen_phase(STACK_DEPTH_DEF + 1);
        wait_drained();

        repeat (4) @(negedge clk);
        while (verdict_q.size() > 0)
        begin
            report_mismatch("result never arrived", 0, verdict_q.pop_front());
        end

        $display("covered %0d characters in %0d strings: %0d balanced, %0d with errors",
                 chars_sent, strings_done, strings_ok, strings_bad);
        $display("deepest nesting %0d, %0d pushes onto a full stack, %0d mismatches",
                 deepest, full_pushes, mismatches);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
